/* hw/rtl/lsra_pkg.sv */
// Shared types and constants for the linear-scan register allocator.
`timescale 1ns / 1ps
package lsra_pkg;

    localparam int NUM_REGS_DEF = 16;
    localparam int ID_W         = 16;
    localparam int POS_W        = 16;
    localparam int PHYS_W       = 6;
    localparam int OFF_W        = 20;
    localparam int FUNC_W       = 2;

    localparam logic [OFF_W-1:0] SPILL_STEP = OFF_W'(4);
    localparam logic [OFF_W-1:0] SPILL_MAX  = {OFF_W{1'b1}};

    localparam logic KIND_REG   = 1'b0;
    localparam logic KIND_SPILL = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_BEGIN = 2'd1,
        FUNC_ALLOC = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_POP,
        S_EVICT1,
        S_EVICT2,
        S_SPILL
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_POP,
        EMIT_EVICT1,
        EMIT_EVICT2,
        EMIT_SPILL
    } emit_t;

    typedef struct packed {
        logic  in_ready;
        logic  push_in;
        logic  begin_fn;
        logic  start_iv;
        logic  scan;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic [FUNC_W-1:0] func;
        logic              scan_done;
        logic              pop_ok;
        logic              evict_ok;
        logic              out_free;
    } status_t;

endpackage

/* hw/rtl/lsra_if.sv */
// Handshake channel interfaces for allocator requests and results.
`timescale 1ns / 1ps
interface lsra_in_if;
    logic                       valid;
    logic                       ready;
    logic [lsra_pkg::FUNC_W-1:0] func;
    logic [lsra_pkg::PHYS_W-1:0] phys_reg;
    logic [lsra_pkg::OFF_W-1:0]  stack_base;
    logic [lsra_pkg::ID_W-1:0]   interval_id;
    logic [lsra_pkg::POS_W-1:0]  interval_start;
    logic [lsra_pkg::POS_W-1:0]  interval_finish;

    modport source (output valid, func, phys_reg, stack_base, interval_id,
                    interval_start, interval_finish, input ready);
    modport sink (input valid, func, phys_reg, stack_base, interval_id,
                  interval_start, interval_finish, output ready);
endinterface

interface lsra_out_if;
    logic                       valid;
    logic                       ready;
    logic [lsra_pkg::ID_W-1:0]   result_id;
    logic                       kind;
    logic [lsra_pkg::PHYS_W-1:0] assigned_reg;
    logic [lsra_pkg::OFF_W-1:0]  spill_offset;
    logic                       last;

    modport source (output valid, result_id, kind, assigned_reg, spill_offset, last,
                    input ready);
    modport sink (input valid, result_id, kind, assigned_reg, spill_offset, last,
                  output ready);
endinterface

/* hw/rtl/lsra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/lsra_ctrl.sv */
// Sequencing state machine for the allocator.
`timescale 1ns / 1ps
module lsra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  lsra_pkg::status_t status,
    output lsra_pkg::cmd_t    cmd
);
    lsra_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsra_pkg::S_IDLE:
            begin
                if (status.in_valid && (status.func == lsra_pkg::FUNC_ALLOC))
                begin
                    state_next = lsra_pkg::S_SCAN;
                end
            end
            lsra_pkg::S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = lsra_pkg::S_DECIDE;
                end
            end
            lsra_pkg::S_DECIDE:
            begin
                priority if (status.pop_ok)
                begin
                    state_next = lsra_pkg::S_POP;
                end
                else if (status.evict_ok)
                begin
                    state_next = lsra_pkg::S_EVICT1;
                end
                else
                begin
                    state_next = lsra_pkg::S_SPILL;
                end
            end
            lsra_pkg::S_POP, lsra_pkg::S_EVICT2, lsra_pkg::S_SPILL:
            begin
                if (status.out_free)
                begin
                    state_next = lsra_pkg::S_IDLE;
                end
            end
            lsra_pkg::S_EVICT1:
            begin
                if (status.out_free)
                begin
                    state_next = lsra_pkg::S_EVICT2;
                end
            end
            default:
            begin
                state_next = lsra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.emit = lsra_pkg::EMIT_NONE;
        unique case (state_reg)
            lsra_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.push_in  = (status.func == lsra_pkg::FUNC_PUSH);
                    cmd.begin_fn = (status.func == lsra_pkg::FUNC_BEGIN);
                    cmd.start_iv = (status.func == lsra_pkg::FUNC_ALLOC);
                end
            end
            lsra_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            lsra_pkg::S_DECIDE:
            begin
            end
            lsra_pkg::S_POP:
            begin
                if (status.out_free) cmd.emit = lsra_pkg::EMIT_POP;
            end
            lsra_pkg::S_EVICT1:
            begin
                if (status.out_free) cmd.emit = lsra_pkg::EMIT_EVICT1;
            end
            lsra_pkg::S_EVICT2:
            begin
                if (status.out_free) cmd.emit = lsra_pkg::EMIT_EVICT2;
            end
            lsra_pkg::S_SPILL:
            begin
                if (status.out_free) cmd.emit = lsra_pkg::EMIT_SPILL;
            end
            default:
            begin
            end
        endcase
    end
endmodule

/* hw/rtl/lsra_dp.sv */
// Datapath: slot and free-stack memories, scan search, spill counter, result register.
`timescale 1ns / 1ps
module lsra_dp #(
    parameter int NUM_REGS = lsra_pkg::NUM_REGS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsra_pkg::cmd_t     cmd,
    output lsra_pkg::status_t  status,
    lsra_in_if.sink            req,
    lsra_out_if.source         res
);
    localparam int IW     = $clog2(NUM_REGS);
    localparam int CW     = $clog2(NUM_REGS + 1);
    localparam int SLOT_W = lsra_pkg::POS_W + lsra_pkg::PHYS_W + lsra_pkg::ID_W;

    // valid bits and counters
    logic [NUM_REGS-1:0]            valid_reg, valid_next;
    logic [CW-1:0]                  pool_count_reg, pool_count_next;
    logic [lsra_pkg::OFF_W-1:0]     next_spill_reg, next_spill_next;
    logic [IW:0]                    cnt_reg, cnt_next;
    // current interval
    logic [lsra_pkg::ID_W-1:0]      id_reg, id_next;
    logic [lsra_pkg::POS_W-1:0]     start_reg, start_next;
    logic [lsra_pkg::POS_W-1:0]     fin_reg, fin_next;
    // search results
    logic                           free_found_reg, free_found_next;
    logic [IW-1:0]                  free_idx_reg, free_idx_next;
    logic                           best_found_reg, best_found_next;
    logic [IW-1:0]                  best_idx_reg, best_idx_next;
    logic [lsra_pkg::POS_W-1:0]     best_fin_reg, best_fin_next;
    logic [lsra_pkg::PHYS_W-1:0]    best_phys_reg, best_phys_next;
    logic [lsra_pkg::ID_W-1:0]      best_id_reg, best_id_next;
    // result register
    logic                           out_valid_reg, out_valid_next;
    logic [lsra_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic                           out_kind_reg, out_kind_next;
    logic [lsra_pkg::PHYS_W-1:0]    out_phys_reg, out_phys_next;
    logic [lsra_pkg::OFF_W-1:0]     out_off_reg, out_off_next;
    logic                           out_last_reg, out_last_next;

    // memory ports
    logic                           slot_we, pool_we;
    logic [IW-1:0]                  slot_waddr, slot_raddr, pool_waddr, pool_raddr;
    logic [SLOT_W-1:0]              slot_wdata, slot_rdata;
    logic [lsra_pkg::PHYS_W-1:0]    pool_wdata, pool_rdata;

    logic [IW-1:0]                  scan_idx, evict_slot;
    logic [lsra_pkg::POS_W-1:0]     scan_fin;
    logic [lsra_pkg::PHYS_W-1:0]    scan_phys;
    logic [lsra_pkg::ID_W-1:0]      scan_id;
    logic                           scan_live, scan_expire, scan_remain;
    logic                           pool_has_room;
    logic [lsra_pkg::OFF_W-1:0]     spill_stepped;

    lsra_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_REGS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    lsra_ram #(.WIDTH(lsra_pkg::PHYS_W), .DEPTH(NUM_REGS)) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    assign slot_raddr = cnt_reg[IW-1:0];
    // top of stack; held steady from decide until the pop commits
    assign pool_raddr = IW'(pool_count_reg - CW'(1));

    assign scan_idx    = IW'(cnt_reg - (IW+1)'(1));
    assign {scan_fin, scan_phys, scan_id} = slot_rdata;
    assign scan_live   = valid_reg[scan_idx];
    assign scan_expire = scan_live && (scan_fin < start_reg);
    assign scan_remain = scan_live && !scan_expire;

    assign pool_has_room = (pool_count_reg < CW'(NUM_REGS));
    assign spill_stepped = (next_spill_reg > (lsra_pkg::SPILL_MAX - lsra_pkg::SPILL_STEP))
                           ? lsra_pkg::SPILL_MAX : (next_spill_reg + lsra_pkg::SPILL_STEP);

    // first free slot once the evicted slot is released
    assign evict_slot = (free_found_reg && (free_idx_reg < best_idx_reg))
                        ? free_idx_reg : best_idx_reg;

    assign req.ready = cmd.in_ready;

    assign status.in_valid  = req.valid;
    assign status.func      = req.func;
    assign status.scan_done = (cnt_reg == (IW+1)'(NUM_REGS));
    assign status.pop_ok    = (pool_count_reg != '0) && free_found_reg;
    assign status.evict_ok  = best_found_reg && (best_fin_reg < fin_reg);
    assign status.out_free  = !out_valid_reg || res.ready;

    assign res.valid        = out_valid_reg;
    assign res.result_id    = out_id_reg;
    assign res.kind         = out_kind_reg;
    assign res.assigned_reg = out_phys_reg;
    assign res.spill_offset = out_off_reg;
    assign res.last         = out_last_reg;

    always_comb
    begin
        valid_next      = valid_reg;
        pool_count_next = pool_count_reg;
        next_spill_next = next_spill_reg;
        cnt_next        = cnt_reg;
        id_next         = id_reg;
        start_next      = start_reg;
        fin_next        = fin_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_fin_next   = best_fin_reg;
        best_phys_next  = best_phys_reg;
        best_id_next    = best_id_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_id_next     = out_id_reg;
        out_kind_next   = out_kind_reg;
        out_phys_next   = out_phys_reg;
        out_off_next    = out_off_reg;
        out_last_next   = out_last_reg;
        slot_we         = 1'b0;
        slot_waddr      = free_idx_reg;
        slot_wdata      = {fin_reg, pool_rdata, id_reg};
        pool_we         = 1'b0;
        pool_waddr      = pool_count_reg[IW-1:0];
        pool_wdata      = req.phys_reg;

        if (cmd.push_in && pool_has_room)
        begin
            pool_we         = 1'b1;
            pool_count_next = pool_count_reg + CW'(1);
        end

        if (cmd.begin_fn)
        begin
            valid_next      = '0;
            pool_count_next = '0;
            next_spill_next = req.stack_base;
        end

        if (cmd.start_iv)
        begin
            id_next         = req.interval_id;
            start_next      = req.interval_start;
            fin_next        = req.interval_finish;
            cnt_next        = '0;
            free_found_next = 1'b0;
            best_found_next = 1'b0;
        end

        if (cmd.scan)
        begin
            cnt_next = cnt_reg + (IW+1)'(1);
            if (cnt_reg != '0)
            begin
                if (scan_expire)
                begin
                    valid_next[scan_idx] = 1'b0;
                    pool_wdata = scan_phys;
                    if (pool_has_room)
                    begin
                        pool_we         = 1'b1;
                        pool_count_next = pool_count_reg + CW'(1);
                    end
                end
                if (!scan_remain && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx;
                end
                // strictly greater keeps the lowest slot on a tie
                if (scan_remain && (!best_found_reg || (scan_fin > best_fin_reg)))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = scan_idx;
                    best_fin_next   = scan_fin;
                    best_phys_next  = scan_phys;
                    best_id_next    = scan_id;
                end
            end
        end

        unique case (cmd.emit)
            lsra_pkg::EMIT_POP:
            begin
                pool_count_next          = pool_count_reg - CW'(1);
                slot_we                  = 1'b1;
                valid_next[free_idx_reg] = 1'b1;
                out_valid_next = 1'b1;
                out_id_next    = id_reg;
                out_kind_next  = lsra_pkg::KIND_REG;
                out_phys_next  = pool_rdata;
                out_off_next   = '0;
                out_last_next  = 1'b1;
            end
            lsra_pkg::EMIT_EVICT1:
            begin
                valid_next[best_idx_reg] = 1'b0;
                next_spill_next = spill_stepped;
                out_valid_next = 1'b1;
                out_id_next    = best_id_reg;
                out_kind_next  = lsra_pkg::KIND_SPILL;
                out_phys_next  = '0;
                out_off_next   = next_spill_reg;
                out_last_next  = 1'b0;
            end
            lsra_pkg::EMIT_EVICT2:
            begin
                slot_we                = 1'b1;
                slot_waddr             = evict_slot;
                slot_wdata             = {fin_reg, best_phys_reg, id_reg};
                valid_next[evict_slot] = 1'b1;
                out_valid_next = 1'b1;
                out_id_next    = id_reg;
                out_kind_next  = lsra_pkg::KIND_REG;
                out_phys_next  = best_phys_reg;
                out_off_next   = '0;
                out_last_next  = 1'b1;
            end
            lsra_pkg::EMIT_SPILL:
            begin
                next_spill_next = spill_stepped;
                out_valid_next = 1'b1;
                out_id_next    = id_reg;
                out_kind_next  = lsra_pkg::KIND_SPILL;
                out_phys_next  = '0;
                out_off_next   = next_spill_reg;
                out_last_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            pool_count_reg <= '0;
            next_spill_reg <= '0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            pool_count_reg <= pool_count_next;
            next_spill_reg <= next_spill_next;
            cnt_reg        <= cnt_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        start_reg     <= start_next;
        fin_reg       <= fin_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        best_fin_reg  <= best_fin_next;
        best_phys_reg <= best_phys_next;
        best_id_reg   <= best_id_next;
        out_id_reg    <= out_id_next;
        out_kind_reg  <= out_kind_next;
        out_phys_reg  <= out_phys_next;
        out_off_reg   <= out_off_next;
        out_last_reg  <= out_last_next;
    end
endmodule

/* hw/rtl/linear_scan_register_allocator.sv */
// Linear-scan register allocator: top level joining controller and datapath.
// Pool push and begin items complete in the idle state, which stays ready for the next item.
// An allocate item scans every slot through one RAM read port before its result
// appears; an eviction gives a second result after the first.
// Reset clears slot valid bits, free-stack count, spill counter and the FSM;
// slot and stack memories need no clearing pass.
`timescale 1ns / 1ps
module linear_scan_register_allocator #(
    parameter int NUM_REGS = lsra_pkg::NUM_REGS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lsra_in_if.sink    alloc_in,
    lsra_out_if.source alloc_out
);
    // Controller steps idle -> scan -> decide -> emit; the datapath owns all
    // storage. The scan reads one slot per cycle, expiring finished intervals
    // back onto the free stack while tracking the first free slot and the
    // latest-finishing live interval. Results leave through one output
    // register, so each emit state waits for the previous transfer.
    lsra_pkg::cmd_t    cmd;
    lsra_pkg::status_t status;

    lsra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    lsra_dp #(.NUM_REGS(NUM_REGS)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (alloc_in),
        .res    (alloc_out)
    );
endmodule

/* bench/linear_scan_register_allocator_tb.sv */
// Self-checking bench for the linear-scan allocator: random and directed requests.
`timescale 1ns / 1ps
module linear_scan_register_allocator_tb;

    localparam int NREG = lsra_pkg::NUM_REGS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [lsra_pkg::FUNC_W-1:0] func;
        logic [lsra_pkg::PHYS_W-1:0] phys_reg;
        logic [lsra_pkg::OFF_W-1:0]  stack_base;
        logic [lsra_pkg::ID_W-1:0]   interval_id;
        logic [lsra_pkg::POS_W-1:0]  interval_start;
        logic [lsra_pkg::POS_W-1:0]  interval_finish;
    } request_t;

    typedef struct packed {
        logic [lsra_pkg::ID_W-1:0]   result_id;
        logic                        kind;
        logic [lsra_pkg::PHYS_W-1:0] assigned_reg;
        logic [lsra_pkg::OFF_W-1:0]  spill_offset;
        logic                        last;
    } decision_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsra_in_if  alloc_in ();
    lsra_out_if alloc_out ();

    linear_scan_register_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .alloc_in  (alloc_in.sink),
        .alloc_out (alloc_out.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Allocator state mirror
    logic                        live_valid [NREG];
    logic [lsra_pkg::POS_W-1:0]  live_finish [NREG];
    logic [lsra_pkg::PHYS_W-1:0] live_reg [NREG];
    logic [lsra_pkg::ID_W-1:0]   live_id [NREG];
    logic [lsra_pkg::PHYS_W-1:0] spare_stack [NREG];
    int                          free_count;
    logic [lsra_pkg::OFF_W-1:0]  spill_next;

    request_t  pending_reqs[$];
    decision_t expected_decisions[$];
    int        mismatches = 0;
    bit        timed_out = 0;
    bit        stim_done = 0;
    bit        hold_sender = 0;   // sender waits for drain
    int        long_stall = 0;    // receiver hold-off, in cycles

    function automatic void free_push(logic [lsra_pkg::PHYS_W-1:0] r);
        if (free_count < NREG)
        begin
            spare_stack[free_count] = r;
            free_count++;
        end
    endfunction

    function automatic logic [lsra_pkg::OFF_W-1:0] spill_take();
        logic [lsra_pkg::OFF_W-1:0] off;
        off = spill_next;
        spill_next = (spill_next > lsra_pkg::SPILL_MAX - lsra_pkg::SPILL_STEP)
                     ? lsra_pkg::SPILL_MAX : spill_next + lsra_pkg::SPILL_STEP;
        return off;
    endfunction

    function automatic int first_open_slot();
        for (int i = 0; i < NREG; i++)
            if (!live_valid[i])
                return i;
        return -1;
    endfunction

    function automatic decision_t mk(logic [lsra_pkg::ID_W-1:0] id, logic k,
                                     logic [lsra_pkg::PHYS_W-1:0] r,
                                     logic [lsra_pkg::OFF_W-1:0] o, logic l);
        decision_t d;
        d.result_id = id; d.kind = k; d.assigned_reg = r; d.spill_offset = o; d.last = l;
        return d;
    endfunction

    // Work out the decisions caused by one accepted request.
    function automatic void allocate_predict(request_t q);
        int slot;
        int best;
        logic [lsra_pkg::PHYS_W-1:0] r;
        if (q.func == lsra_pkg::FUNC_PUSH)
            free_push(q.phys_reg);
        else if (q.func == lsra_pkg::FUNC_BEGIN)
        begin
            foreach (live_valid[i]) live_valid[i] = 1'b0;
            free_count = 0;
            spill_next = q.stack_base;
        end
        else if (q.func == lsra_pkg::FUNC_ALLOC)
        begin
            // expire intervals finished before this start, in slot order
            for (int i = 0; i < NREG; i++)
                if (live_valid[i] && live_finish[i] < q.interval_start)
                begin
                    live_valid[i] = 1'b0;
                    free_push(live_reg[i]);
                end
            slot = first_open_slot();
            if (free_count > 0 && slot >= 0)
            begin
                free_count--;
                live_valid[slot] = 1'b1;
                live_finish[slot] = q.interval_finish;
                live_reg[slot] = spare_stack[free_count];
                live_id[slot] = q.interval_id;
                expected_decisions.push_back(mk(q.interval_id, lsra_pkg::KIND_REG,
                                                live_reg[slot], '0, 1'b1));
                return;
            end
            // latest finish, ties to lowest slot
            best = -1;
            for (int i = 0; i < NREG; i++)
                if (live_valid[i] && (best < 0 || live_finish[i] > live_finish[best]))
                    best = i;
            if (best >= 0 && live_finish[best] < q.interval_finish)
            begin
                r = live_reg[best];
                expected_decisions.push_back(mk(live_id[best], lsra_pkg::KIND_SPILL, '0,
                                                spill_take(), 1'b0));
                live_valid[best] = 1'b0;
                slot = first_open_slot();
                if (slot < 0) slot = best;
                live_valid[slot] = 1'b1;
                live_finish[slot] = q.interval_finish;
                live_reg[slot] = r;
                live_id[slot] = q.interval_id;
                expected_decisions.push_back(mk(q.interval_id, lsra_pkg::KIND_REG, r, '0,
                                                1'b1));
            end
            else
                expected_decisions.push_back(mk(q.interval_id, lsra_pkg::KIND_SPILL, '0,
                                                spill_take(), 1'b1));
        end
        // func code 3: ignored
    endfunction

    function automatic request_t req(logic [lsra_pkg::FUNC_W-1:0] f,
                                     logic [lsra_pkg::PHYS_W-1:0] p,
                                     logic [lsra_pkg::OFF_W-1:0] b,
                                     logic [lsra_pkg::ID_W-1:0] id,
                                     logic [lsra_pkg::POS_W-1:0] s,
                                     logic [lsra_pkg::POS_W-1:0] e);
        request_t q;
        q.func = f; q.phys_reg = p; q.stack_base = b;
        q.interval_id = id; q.interval_start = s; q.interval_finish = e;
        return q;
    endfunction

    function automatic request_t noise_req(logic [lsra_pkg::FUNC_W-1:0] f);
        return req(f, 6'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
    endfunction

    // Driver: pops pending requests, random gap before each transfer
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_in.valid <= 1'b0;
            alloc_in.func <= '0;
            alloc_in.phys_reg <= '0;
            alloc_in.stack_base <= '0;
            alloc_in.interval_id <= '0;
            alloc_in.interval_start <= '0;
            alloc_in.interval_finish <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (alloc_in.valid && alloc_in.ready)
            begin
                allocate_predict(request_t'({alloc_in.func, alloc_in.phys_reg,
                    alloc_in.stack_base, alloc_in.interval_id,
                    alloc_in.interval_start, alloc_in.interval_finish}));
                void'(pending_reqs.pop_front());
            end
            if (!alloc_in.valid || alloc_in.ready)
            begin
                if (alloc_in.valid && alloc_in.ready)
                begin
                    alloc_in.valid <= 1'b0;
                    send_gap <= $urandom_range(0, 3);
                end
                else if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_reqs.size() > 0 && !hold_sender)
                begin
                    alloc_in.valid <= 1'b1;
                    {alloc_in.func, alloc_in.phys_reg, alloc_in.stack_base,
                     alloc_in.interval_id, alloc_in.interval_start,
                     alloc_in.interval_finish} <= pending_reqs[0];
                end
            end
        end
    end

    // Monitor: compares each result transfer, random receiver stalls
    int recv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        decision_t got;
        decision_t want;
        if (!rst_n)
        begin
            alloc_out.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (alloc_out.valid && alloc_out.ready)
            begin
                got = {alloc_out.result_id, alloc_out.kind, alloc_out.assigned_reg,
                       alloc_out.spill_offset, alloc_out.last};
                if (expected_decisions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %h", got);
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: id %h/%h kind %b/%b reg %0d/%0d",
                                      " off %h/%h last %b/%b"},
                                want.result_id, got.result_id, want.kind, got.kind,
                                want.assigned_reg, got.assigned_reg,
                                want.spill_offset, got.spill_offset, want.last, got.last);
                    end
                end
            end
            if (long_stall > 0)
                alloc_out.ready <= 1'b0;
            else if (alloc_out.valid && alloc_out.ready)
            begin
                recv_gap <= $urandom_range(0, 3);
                alloc_out.ready <= 1'b0;
            end
            else if (recv_gap > 0)
                recv_gap <= recv_gap - 1;
            else
                alloc_out.ready <= 1'b1;
        end
    end

    // Hold-off counter, in its own process
    always @(posedge clk)
        if (long_stall > 0)
            long_stall <= long_stall - 1;

    // Watchdog: cycles without any transfer
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((alloc_in.valid && alloc_in.ready) || (alloc_out.valid && alloc_out.ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Regression FAIL");
            $finish;
        end
    end

    // Well-formed function: begin, a pool, then sorted intervals
    task automatic queue_function(int n_pool, int n_iv, int span);
        int pos;
        int fin;
        pending_reqs.push_back(req(lsra_pkg::FUNC_BEGIN, '0, 20'($urandom), '0, '0, '0));
        repeat (n_pool)
            pending_reqs.push_back(req(lsra_pkg::FUNC_PUSH, 6'($urandom), '0, '0, '0, '0));
        pos = $urandom_range(0, 200);
        repeat (n_iv)
        begin
            pos += $urandom_range(0, 4);
            if (pos > 65535) pos = 65535;
            fin = pos + $urandom_range(0, span);
            if (fin > 65535) fin = 65535;
            pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'($urandom),
                                       16'(pos), 16'(fin)));
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_decisions.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int r;
        foreach (live_valid[i]) live_valid[i] = 1'b0;
        free_count = 0;
        spill_next = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: saturating spill, eviction, ties, full stack, no-free-slot, code 3
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'hFFFF, 16'd0, 16'hFFFF));
        pending_reqs.push_back(req(lsra_pkg::FUNC_BEGIN, '0, 20'hFFFFA, '0, '0, '0));
        pending_reqs.push_back(req(lsra_pkg::FUNC_PUSH, 6'd63, '0, '0, '0, '0));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'h0001, 16'd0, 16'd10));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'h0002, 16'd1, 16'd10));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'h0003, 16'd2, 16'd20));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'h0004, 16'd3, 16'd5));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'h0005, 16'd4, 16'd30));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'h0006, 16'd31, 16'hFFFF));
        pending_reqs.push_back(req(2'd3, 6'h3F, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(req(lsra_pkg::FUNC_BEGIN, '0, 20'd0, '0, '0, '0));
        for (int i = 0; i < 18; i++)
            pending_reqs.push_back(req(lsra_pkg::FUNC_PUSH, 6'(i), '0, '0, '0, '0));
        drain();
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'(i), 16'd100,
                                       16'd200));
        pending_reqs.push_back(req(lsra_pkg::FUNC_ALLOC, '0, '0, 16'hAAAA, 16'd201,
                                   16'd300));
        drain();

        // Receiver holds off while sender keeps offering
        queue_function(12, 30, 60);
        long_stall = 400;
        drain();

        // Random: mostly well-formed functions, some noise
        while (pending_reqs.size() + 0 == 0 && stim_done == 0)
        begin
            for (int k = 0; k < 56; k++)
            begin
                r = $urandom_range(0, 9);
                if (r < 8)
                    queue_function($urandom_range(0, 20), $urandom_range(1, 40),
                                   (r < 4) ? 30 : 65535);
                else
                    repeat ($urandom_range(1, 6))
                        pending_reqs.push_back(noise_req(2'($urandom)));
                if (k == 20)
                begin
                    // sender pauses until all results are back
                    repeat (200) @(posedge clk);
                    hold_sender = 1;
                    while (expected_decisions.size() > 0 || alloc_in.valid)
                        @(posedge clk);
                    hold_sender = 0;
                end
            end
            stim_done = 1;
        end
        drain();
        repeat (NREG * 4 + 20) @(posedge clk);

        if (mismatches == 0 && expected_decisions.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/lsra_pkg.sv
hw/rtl/lsra_if.sv
hw/rtl/lsra_ram.sv
hw/rtl/lsra_ctrl.sv
hw/rtl/lsra_dp.sv
hw/rtl/linear_scan_register_allocator.sv
bench/linear_scan_register_allocator_tb.sv
